// ===== hw/rtl/spr_pkg.sv =====
// shared types, constants and helpers for the stream pattern replace block
`timescale 1ns / 1ps

package spr_pkg;

  // pattern window depth and replacement limit
  localparam int unsigned PatternBytes = 8;
  localparam int unsigned MaxRepl      = 8;
  localparam int unsigned IdxW         = $clog2(PatternBytes);
  localparam int unsigned LenW         = 4;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned CfgIdxW      = 2;

  // command queue depth
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = CmdPtrW + 1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBytes     = 2'd0,
    CfgPatternLength    = 2'd1,
    CfgReplacementBytes = 2'd2,
    CfgReplacementLength = 2'd3
  } cfg_reg_e;

  // input word
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } text_word_t;

  // output word
  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_has_byte;
    logic       result_last;
  } result_word_t;

  // one classified input: up to eight bytes to emit, and the end flag
  typedef struct packed {
    logic [8*MaxRepl-1:0] data;
    logic [LenW-1:0]      count;
    logic                 last;
  } cmd_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // pattern length as used: zero acts as one, clipped to the window depth
  function automatic logic [LenW-1:0] eff_pat_len(logic [LenW-1:0] len);
    logic [LenW-1:0] l;
    l = len;
    if (l == '0) l = LenW'(1);
    if (l > LenW'(PatternBytes)) l = LenW'(PatternBytes);
    return l;
  endfunction

  // replacement length as used: clipped to the replacement limit
  function automatic logic [LenW-1:0] eff_repl_len(logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = len;
    if (r > LenW'(MaxRepl)) r = LenW'(MaxRepl);
    return r;
  endfunction

endpackage

// ===== hw/rtl/spr_front.sv =====
// front end: configuration registers, match window and word classification
`timescale 1ns / 1ps

module spr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [spr_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              text_valid_i,
  output logic                              text_stall_o,
  input  spr_pkg::text_word_t               text_i,
  input  spr_pkg::fifo_stat_t               fifo_stat_i,
  output logic                              push_o,
  output spr_pkg::cmd_t                     cmd_o
);

  localparam int unsigned Pb = spr_pkg::PatternBytes;

  logic [spr_pkg::CfgDataW-1:0] pat_q, repl_q;
  logic [spr_pkg::LenW-1:0]     pat_len_q, repl_len_q;
  logic [spr_pkg::IdxW-1:0]     fill_q, fill_d;
  logic [7:0]                   win_q [Pb];
  logic [7:0]                   win_d [Pb];
  logic [7:0]                   w [Pb];

  logic [spr_pkg::LenW-1:0] pat_len, repl_len, new_fill;
  logic [spr_pkg::IdxW-1:0] wr_idx;
  logic                     accept, full, match, hit;

  assign text_stall_o = fifo_stat_i.full;
  assign accept       = text_valid_i && !fifo_stat_i.full;

  // insert the byte, compare and classify
  always_comb begin
    pat_len  = spr_pkg::eff_pat_len(pat_len_q);
    repl_len = spr_pkg::eff_repl_len(repl_len_q);
    wr_idx   = ({1'b0, fill_q} >= pat_len) ? '0 : fill_q;
    for (int i = 0; i < Pb; i++) begin
      w[i] = (wr_idx == spr_pkg::IdxW'(i)) ? text_i.text_byte : win_q[i];
    end
    new_fill = {1'b0, wr_idx} + spr_pkg::LenW'(1);
    full     = (new_fill == pat_len);
    match    = 1'b1;
    for (int i = 0; i < Pb; i++) begin
      if ((spr_pkg::LenW'(i) < pat_len) && (w[i] != pat_q[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    hit = full && match;

    // command for the back end
    cmd_o.last = text_i.text_last;
    if (hit) begin
      cmd_o.data  = repl_q;
      cmd_o.count = repl_len;
    end else begin
      for (int i = 0; i < Pb; i++) begin
        cmd_o.data[8*i +: 8] = w[i];
      end
      if (text_i.text_last) begin
        cmd_o.count = new_fill;
      end else if (full) begin
        cmd_o.count = spr_pkg::LenW'(1);
      end else begin
        cmd_o.count = '0;
      end
    end
    push_o = accept && ((cmd_o.count != '0) || text_i.text_last);

    // next window contents
    if (hit) begin
      win_d  = w;
      fill_d = '0;
    end else if (full) begin
      for (int i = 0; i < Pb - 1; i++) begin
        win_d[i] = w[i+1];
      end
      win_d[Pb-1] = w[Pb-1];
      fill_d      = spr_pkg::IdxW'(pat_len - spr_pkg::LenW'(1));
    end else begin
      win_d  = w;
      fill_d = new_fill[spr_pkg::IdxW-1:0];
    end
    if (text_i.text_last) fill_d = '0;
  end

  // configuration registers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      pat_len_q  <= spr_pkg::LenW'(1);
      repl_q     <= '0;
      repl_len_q <= '0;
      fill_q     <= '0;
    end else if (cfg_we_i) begin
      case (spr_pkg::cfg_reg_e'(cfg_idx_i))
        spr_pkg::CfgPatternBytes: pat_q <= cfg_data_i;
        spr_pkg::CfgPatternLength: begin
          pat_len_q <= cfg_data_i[spr_pkg::LenW-1:0];
          fill_q    <= '0;
        end
        spr_pkg::CfgReplacementBytes:  repl_q     <= cfg_data_i;
        spr_pkg::CfgReplacementLength: repl_len_q <= cfg_data_i[spr_pkg::LenW-1:0];
        default: ;
      endcase
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // window bytes
  always_ff @(posedge clk_i) begin
    if (accept) win_q <= win_d;
  end

endmodule

// ===== hw/rtl/spr_cmd_fifo.sv =====
// short command queue between the front and back ends
`timescale 1ns / 1ps

module spr_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  spr_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output spr_pkg::cmd_t       head_o,
  output spr_pkg::fifo_stat_t stat_o
);

  spr_pkg::cmd_t                 mem_q [spr_pkg::CmdDepth];
  logic [spr_pkg::CmdPtrW-1:0]   wptr_q, rptr_q;
  logic [spr_pkg::CmdCntW-1:0]   cnt_q;

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == spr_pkg::CmdCntW'(spr_pkg::CmdDepth));
  assign stat_o.empty = (cnt_q == '0);

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + spr_pkg::CmdPtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + spr_pkg::CmdPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + spr_pkg::CmdCntW'(1);
        2'b01:   cnt_q <= cnt_q - spr_pkg::CmdCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= cmd_i;
  end

endmodule

// ===== hw/rtl/spr_back.sv =====
// back end: unpacks commands into result words through an output register
`timescale 1ns / 1ps

module spr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spr_pkg::cmd_t         head_i,
  input  spr_pkg::fifo_stat_t   fifo_stat_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  input  logic                  result_stall_i,
  output spr_pkg::result_word_t result_o
);

  logic [spr_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     valid_q, valid_d;
  spr_pkg::result_word_t    word_q, word_d;
  logic [spr_pkg::LenW-1:0] last_idx;
  logic                     at_end, load;

  // pick the current byte of the head command
  always_comb begin
    last_idx = (head_i.count == '0) ? '0 : head_i.count - spr_pkg::LenW'(1);
    at_end   = ({1'b0, idx_q} == last_idx);
    load     = !fifo_stat_i.empty && (!valid_q || !result_stall_i);
    pop_o    = load && at_end;

    word_d.result_byte     = (head_i.count == '0) ? 8'd0 : head_i.data[{idx_q, 3'b000} +: 8];
    word_d.result_has_byte = (head_i.count != '0);
    word_d.result_last     = head_i.last && at_end;

    idx_d = idx_q;
    if (load) idx_d = at_end ? '0 : idx_q + spr_pkg::IdxW'(1);

    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!result_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (load) word_q <= word_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = word_q;

endmodule

// ===== hw/rtl/stream_pattern_replace.sv =====
// top level of the streaming find-and-replace block
//
//  channel   direction  handshake                     payload
//  text      in         text_valid_i / text_stall_o   text_i (text_word_t)
//  result    out        result_valid_o / result_stall_i result_o (result_word_t)
//  cfg       in         cfg_we_i                      cfg_idx_i, cfg_data_i
//
// the front end takes one text word per cycle while the command queue has room
// each text word yields zero to eight result words, emitted one per cycle
// from the output register while the result is not stalled; the four-entry command queue absorbs bursts
// an accepted word goes through a command queue entry, then the output register, before its first result
// reset empties the window, the queue and the output register at once
// a stalled result holds in the output register; text stalls only on a full queue
`timescale 1ns / 1ps

module stream_pattern_replace (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         text_valid_i,
  output logic                         text_stall_o,
  input  spr_pkg::text_word_t          text_i,
  output logic                         result_valid_o,
  input  logic                         result_stall_i,
  output spr_pkg::result_word_t        result_o
);

  logic                cmd_push, cmd_pop;
  spr_pkg::cmd_t       cmd, head;
  spr_pkg::fifo_stat_t fifo_stat;

  // classification
  spr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .text_valid_i (text_valid_i),
    .text_stall_o (text_stall_o),
    .text_i       (text_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (cmd_push),
    .cmd_o        (cmd)
  );

  // command queue
  spr_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd),
    .pop_i  (cmd_pop),
    .head_o (head),
    .stat_o (fifo_stat)
  );

  // emission
  spr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .fifo_stat_i    (fifo_stat),
    .pop_o          (cmd_pop),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .result_o       (result_o)
  );

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_push && fifo_stat.full))
    else $error("command queue overflow");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !fifo_stat.empty)
    else $error("command queue underflow");

  // a word without a byte is only ever the end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (result_valid_o && !result_o.result_has_byte) |-> result_o.result_last)
    else $error("empty result word that is not the end marker");

endmodule

// ===== tb/stream_pattern_replace_checker.sv =====
// watches the text, result and register ports, predicts each result word and compares
`timescale 1ns / 1ps

module stream_pattern_replace_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [spr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          text_valid_i,
  input  logic                          text_stall_i,
  input  spr_pkg::text_word_t           text_i,
  input  logic                          result_valid_i,
  input  logic                          result_stall_i,
  input  spr_pkg::result_word_t         result_i,
  output int                            fail_count_o,
  output int                            words_due_o
);

  localparam int unsigned Depth   = spr_pkg::PatternBytes;
  localparam int unsigned ReplMax = spr_pkg::MaxRepl;

  // own copy of the registers and the match window
  logic [spr_pkg::CfgDataW-1:0] pattern_q;
  logic [spr_pkg::LenW-1:0]     pattern_len_q;
  logic [spr_pkg::CfgDataW-1:0] replacement_q;
  logic [spr_pkg::LenW-1:0]     replacement_len_q;
  logic [7:0]                   window_q [Depth];
  int unsigned                  fill_q;

  // rewritten words still owed by the block, oldest first
  spr_pkg::result_word_t        rewritten_words [$];
  spr_pkg::result_word_t        got_word;
  spr_pkg::result_word_t        want_word;

  // queue one plain character of the rewritten string
  function automatic void push_char(input logic [7:0] c);
    spr_pkg::result_word_t w;
    w.result_byte     = c;
    w.result_has_byte = 1'b1;
    w.result_last     = 1'b0;
    rewritten_words.push_back(w);
  endfunction

  // advance the window by one text word and queue the words it releases
  task automatic predict_rewrite(input spr_pkg::text_word_t w);
    int unsigned           plen;
    int unsigned           rlen;
    int unsigned           first;
    int unsigned           i;
    bit                    hit;
    spr_pkg::result_word_t tail;
    plen = (pattern_len_q == 0) ? 1 :
           ((pattern_len_q > Depth) ? Depth : int'(pattern_len_q));
    rlen = (replacement_len_q > ReplMax) ? ReplMax : int'(replacement_len_q);
    first = rewritten_words.size();
    if (fill_q >= plen) fill_q = 0;
    window_q[fill_q] = w.text_byte;
    fill_q++;
    // full window: replace on a match, else release the oldest character
    if (fill_q == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (window_q[i] != pattern_q[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < rlen; i++) push_char(replacement_q[8*i +: 8]);
        fill_q = 0;
      end else begin
        push_char(window_q[0]);
        for (i = 1; i < plen; i++) window_q[i-1] = window_q[i];
        fill_q = plen - 1;
      end
    end
    // end of string: flush, then mark the final word or send a bare marker
    if (w.text_last) begin
      for (i = 0; i < fill_q; i++) push_char(window_q[i]);
      fill_q = 0;
      if (rewritten_words.size() == first) begin
        tail.result_byte     = 8'h00;
        tail.result_has_byte = 1'b0;
        tail.result_last     = 1'b1;
      end else begin
        tail = rewritten_words.pop_back();
        tail.result_last = 1'b1;
      end
      rewritten_words.push_back(tail);
    end
  endtask

  // sample every handshake at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q         = '0;
      pattern_len_q     = spr_pkg::LenW'(1);
      replacement_q     = '0;
      replacement_len_q = '0;
      fill_q            = 0;
      fail_count_o      = 0;
      rewritten_words.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spr_pkg::CfgPatternBytes: begin
            pattern_q = cfg_data_i;
          end
          spr_pkg::CfgPatternLength: begin
            pattern_len_q = cfg_data_i[spr_pkg::LenW-1:0];
            fill_q = 0;
          end
          spr_pkg::CfgReplacementBytes: begin
            replacement_q = cfg_data_i;
          end
          spr_pkg::CfgReplacementLength: begin
            replacement_len_q = cfg_data_i[spr_pkg::LenW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (text_valid_i && !text_stall_i) predict_rewrite(text_i);
      // compare an accepted result word with the oldest one owed
      if (result_valid_i && !result_stall_i) begin
        got_word = result_i;
        if (rewritten_words.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected result word: byte %02h has %0d last %0d", $realtime,
                     got_word.result_byte, got_word.result_has_byte, got_word.result_last);
          end
          fail_count_o++;
        end else begin
          want_word = rewritten_words.pop_front();
          if (got_word.result_byte !== want_word.result_byte ||
              got_word.result_has_byte !== want_word.result_has_byte ||
              got_word.result_last !== want_word.result_last) begin
            if (fail_count_o < 10) begin
              $display({"%0t: result word mismatch: want byte %02h has %0d last %0d, ",
                        "got byte %02h has %0d last %0d"},
                       $realtime, want_word.result_byte, want_word.result_has_byte,
                       want_word.result_last, got_word.result_byte,
                       got_word.result_has_byte, got_word.result_last);
            end
            fail_count_o++;
          end
        end
      end
    end
    words_due_o = rewritten_words.size();
  end

endmodule

// ===== tb/stream_pattern_replace_test.sv =====
// top of the find-and-replace test: clock, reset, register writes, text and result traffic
`timescale 1ns / 1ps

module stream_pattern_replace_test;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseWords   = 25;
  localparam longint      LimitNs      = 2_000_000;

  typedef logic [7:0] char_q_t [$];

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [spr_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [spr_pkg::CfgDataW-1:0] cfg_data;
  logic                         text_valid;
  logic                         text_stall;
  spr_pkg::text_word_t          text_word;
  logic                         result_valid;
  logic                         result_stall;
  spr_pkg::result_word_t        result_word;
  int                           fail_count;
  int                           words_due;
  bit                           sender_idle;
  bit                           receiver_idle;
  int unsigned                  stall_left;

  stream_pattern_replace dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .text_valid_i   (text_valid),
    .text_stall_o   (text_stall),
    .text_i         (text_word),
    .result_valid_o (result_valid),
    .result_stall_i (result_stall),
    .result_o       (result_word)
  );

  stream_pattern_replace_checker rewrite_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .text_valid_i   (text_valid),
    .text_stall_i   (text_stall),
    .text_i         (text_word),
    .result_valid_i (result_valid),
    .result_stall_i (result_stall),
    .result_i       (result_word),
    .fail_count_o   (fail_count),
    .words_due_o    (words_due)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #(LimitNs);
    $display("** stream_pattern_replace: FAILED **");
    $finish;
  end

  // result side: random stall bursts while enabled
  initial begin
    result_stall <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      result_stall <= (stall_left != 0);
    end
  end

  // one register write, with the write enable dropped again before the next write
  task automatic write_reg(input spr_pkg::cfg_reg_e idx,
                           input logic [spr_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_rewrite(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen);
    write_reg(spr_pkg::CfgPatternBytes, pat);
    write_reg(spr_pkg::CfgPatternLength, spr_pkg::CfgDataW'(plen));
    write_reg(spr_pkg::CfgReplacementBytes, rep);
    write_reg(spr_pkg::CfgReplacementLength, spr_pkg::CfgDataW'(rlen));
  endtask

  // offer one text word, maybe after a gap, and hold it until taken
  task automatic send_word(input logic [7:0] c, input bit last);
    spr_pkg::text_word_t w;
    w.text_byte = c;
    w.text_last = last;
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_word  <= w;
    @(posedge clk);
    while (text_stall) @(posedge clk);
  endtask

  task automatic send_string(input char_q_t chars, input bit closes);
    int unsigned i;
    for (i = 0; i < chars.size(); i++) send_word(chars[i], closes && i == chars.size() - 1);
  endtask

  // stop sending until every owed word is out, then let the pipeline go quiet
  task automatic settle();
    text_valid <= 1'b0;
    do @(negedge clk); while (words_due != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // random settings, then strings built mostly from pattern copies and near misses
  task automatic random_phase(input int unsigned budget);
    logic [7:0]  letters [3];
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int unsigned span;
    int unsigned sent;
    int unsigned kind;
    int unsigned cut;
    int unsigned k;
    char_q_t     line;
    for (k = 0; k < 3; k++) letters[k] = 8'($urandom);
    pat = {$urandom, $urandom};
    rep = {$urandom, $urandom};
    for (k = 0; k < 8; k++) pat[8*k +: 8] = letters[$urandom_range(0, 2)];
    if ($urandom_range(0, 5) == 0) plen = 4'($urandom_range(0, 15));
    else plen = 4'($urandom_range(1, 4));
    rlen = 4'($urandom_range(0, 15));
    span = (plen == 0) ? 1 : ((plen > 8) ? 8 : int'(plen));
    set_rewrite(pat, plen, rep, rlen);
    sent = 0;
    while (sent < budget) begin
      line = {};
      repeat ($urandom_range(1, 5)) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          for (k = 0; k < span; k++) line.push_back(pat[8*k +: 8]);
        end else if (kind < 6) begin
          cut = $urandom_range(0, span - 1);
          for (k = 0; k < cut; k++) line.push_back(pat[8*k +: 8]);
          line.push_back(letters[$urandom_range(0, 2)]);
        end else if (kind < 9) begin
          line.push_back(letters[$urandom_range(0, 2)]);
        end else begin
          line.push_back(8'($urandom));
        end
      end
      send_string(line, 1'b1);
      sent += line.size();
    end
    settle();
  endtask

  // stimulus and verdict
  initial begin
    char_q_t     line;
    int unsigned p;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= spr_pkg::CfgPatternBytes;
    cfg_data      <= '0;
    text_valid    <= 1'b0;
    text_word     <= '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: the zero character is deleted, end of an otherwise empty string gives a bare marker
    line = '{8'h00};
    send_string(line, 1'b1);
    line = '{8'h00, 8'hFF};
    send_string(line, 1'b1);
    settle();

    // short pattern, longer replacement, leftover window flushed at the end
    set_rewrite(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    line = '{8'h61, 8'h61, 8'h62, 8'h61, 8'h62};
    send_string(line, 1'b1);
    line = '{8'h61};
    send_string(line, 1'b1);
    settle();

    // zero length acts as one, oversized replacement clipped to eight
    set_rewrite('1, 4'd0, '1, 4'd15);
    line = '{8'hFF};
    send_string(line, 1'b1);
    line = '{8'h00};
    send_string(line, 1'b1);
    settle();

    // oversized pattern length clipped to eight, full match deleted at end of string
    set_rewrite(64'h0807060504030201, 4'd15, '0, 4'd0);
    line = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
    send_string(line, 1'b1);
    // partly filled window dropped by a length write in mid string
    line = '{8'h01, 8'h02, 8'h09};
    send_string(line, 1'b0);
    settle();
    write_reg(spr_pkg::CfgPatternLength, spr_pkg::CfgDataW'(2));
    line = '{8'h01, 8'h02, 8'h03};
    send_string(line, 1'b1);
    settle();

    // random part, the last phase without any idling
    for (p = 0; p < 7; p++) begin
      sender_idle   = (p != 2) && (p != 6);
      receiver_idle = (p != 6);
      random_phase(PhaseWords);
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** stream_pattern_replace: PASSED **");
    end else begin
      $display("** stream_pattern_replace: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spr_pkg.sv
hw/rtl/spr_front.sv
hw/rtl/spr_cmd_fifo.sv
hw/rtl/spr_back.sv
hw/rtl/stream_pattern_replace.sv
tb/stream_pattern_replace_checker.sv
tb/stream_pattern_replace_test.sv
